### hdl/kts_pkg.sv
// Package for the topological sort block: sizes, types, request codes and
// the controller/datapath command and status structs. No dependencies.
package kts_pkg;
    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 256;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int LW = EW + 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_EDGES);

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

    typedef struct packed {
        logic            action;
        logic [VW-1:0]   src_vertex;
        logic [VW-1:0]   dst_vertex;
    } t_req;

    typedef struct packed {
        logic [VW-1:0]   vertex;
        logic            done_res;
        logic [CW-1:0]   unsorted_count;
        logic            edges_dropped;
    } t_res;

    typedef struct packed {
        logic add_edge;
        logic seed_step;
        logic pop;
        logic edge_rd;
        logic edge_use;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic seed_last;
        logic fifo_empty;
        logic edge_null;
    } t_sts;
endpackage

### hdl/kts_if.sv
// Valid/ready channel interfaces, one for requests and one for results.
// Depends on kts_pkg.
interface kts_req_if import kts_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kts_res_if import kts_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/kahn_topological_sort.sv
// Kahn topological sort. An edge request is accepted while idle. A run request
// scans all 32 vertices, then emits each vertex taken from the ready FIFO
// and walks its outgoing edges one edge memory read at a time,
// and ends with one summary result; the store is cleared in the cycle the
// summary is taken. Depends on kts_pkg, kts_if, kts_ctrl and kts_datapath.
module kahn_topological_sort import kts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    kts_req_if.sink   i_req,
    kts_res_if.source o_res
);
    t_cmd          cmd;
    t_sts          sts;
    logic          done;
    logic [VW-1:0] v;
    logic [CW-1:0] uns;
    logic          drop;

    kts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.data.action),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_done  (done),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    kts_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_vertex   (v),
        .o_unsorted (uns),
        .o_dropped  (drop)
    );

    assign o_res.data.vertex         = done ? '0 : v;
    assign o_res.data.done_res       = done;
    assign o_res.data.unsorted_count = done ? uns : '0;
    assign o_res.data.edges_dropped  = done & drop;
endmodule

### hdl/kts_datapath.sv
// Datapath: adjacency lists in an edge memory, in-degree and present
// registers, ready FIFO and run counters. Depends on kts_pkg.
module kts_datapath import kts_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_req          i_req,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    output logic [VW-1:0] o_vertex,
    output logic [CW-1:0] o_unsorted,
    output logic          o_dropped
);
    logic [VW-1:0] r_tgt [MAX_EDGES];
    logic [LW-1:0] r_lnk [MAX_EDGES];
    logic [VW-1:0] r_fifo [MAX_VERTICES];
    logic [LW-1:0] r_head [MAX_VERTICES];
    logic [LW-1:0] r_tail [MAX_VERTICES];
    logic [LW-1:0] r_deg  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_present;
    logic [LW-1:0] r_ecount;
    logic          r_drop;
    logic [VW-1:0] r_seed;
    logic [CW-1:0] r_fhead, r_ftail, r_npresent, r_emitted;
    logic [LW-1:0] r_e;
    logic [VW-1:0] r_w;
    logic [LW-1:0] r_nxt;
    logic [VW-1:0] r_v;
    logic [VW-1:0] s, d, w;
    logic          full;

    assign s = i_req.src_vertex;
    assign d = i_req.dst_vertex;
    assign full = (r_ecount >= LW'(MAX_EDGES));
    assign w = r_w;

    // link of a list's last edge is never written; the walk stops at the tail
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_edge && !full)
            r_tgt[r_ecount[EW-1:0]] <= d;
        if (i_cmd.add_edge && !full && r_tail[s] != NULL_LINK)
            r_lnk[r_tail[s][EW-1:0]] <= r_ecount;
        if (i_cmd.edge_rd) begin
            r_w   <= r_tgt[r_e[EW-1:0]];
            r_nxt <= r_lnk[r_e[EW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_head[i] <= NULL_LINK;
                r_tail[i] <= NULL_LINK;
                r_deg[i]  <= '0;
            end
            r_present  <= '0;
            r_ecount   <= '0;
            r_drop     <= 1'b0;
            r_seed     <= '0;
            r_fhead    <= '0;
            r_ftail    <= '0;
            r_npresent <= '0;
            r_emitted  <= '0;
            r_e        <= NULL_LINK;
            r_v        <= '0;
        end else begin
            if (i_cmd.add_edge) begin
                r_present[s] <= 1'b1;
                r_present[d] <= 1'b1;
                if (full) begin
                    r_drop <= 1'b1;
                end else begin
                    if (r_tail[s] == NULL_LINK)
                        r_head[s] <= r_ecount;
                    r_tail[s] <= r_ecount;
                    r_deg[d]  <= r_deg[d] + 1'b1;
                    r_ecount  <= r_ecount + 1'b1;
                end
            end
            if (i_cmd.seed_step) begin
                if (r_present[r_seed]) begin
                    r_npresent <= r_npresent + 1'b1;
                    if (r_deg[r_seed] == '0) begin
                        r_fifo[r_ftail[VW-1:0]] <= r_seed;
                        r_ftail <= r_ftail + 1'b1;
                    end
                end
                r_seed <= r_seed + 1'b1;
            end
            if (i_cmd.pop) begin
                r_v       <= r_fifo[r_fhead[VW-1:0]];
                r_e       <= r_head[r_fifo[r_fhead[VW-1:0]]];
                r_fhead   <= r_fhead + 1'b1;
                r_emitted <= r_emitted + 1'b1;
            end
            if (i_cmd.edge_use) begin
                r_e <= (r_e == r_tail[r_v]) ? NULL_LINK : r_nxt;
                if (r_deg[w] != '0) begin
                    r_deg[w] <= r_deg[w] - 1'b1;
                    if (r_deg[w] == LW'(1)) begin
                        r_fifo[r_ftail[VW-1:0]] <= w;
                        r_ftail <= r_ftail + 1'b1;
                    end
                end
            end
        end
    end

    assign o_sts.seed_last  = (r_seed == VW'(MAX_VERTICES - 1));
    assign o_sts.fifo_empty = (r_fhead == r_ftail);
    assign o_sts.edge_null  = (r_e >= r_ecount) || (r_e >= LW'(MAX_EDGES));
    assign o_vertex   = r_v;
    assign o_unsorted = r_npresent - r_emitted;
    assign o_dropped  = r_drop;
endmodule

### hdl/kts_ctrl.sv
// Controller state machine sequencing edge loads, seeding, the graph
// walk and the result handshake. Depends on kts_pkg.
module kts_ctrl import kts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_action,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  o_out_done,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SEED = 7'b0000010,
        S_POP  = 7'b0000100,
        S_EMIT = 7'b0001000,
        S_RD   = 7'b0010000,
        S_USE  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_RUN) n_state = S_SEED;
                    else                     o_cmd.add_edge = 1'b1;
                end
            end
            S_SEED: begin
                o_cmd.seed_step = 1'b1;
                if (i_sts.seed_last) n_state = S_POP;
            end
            S_POP: begin
                if (i_sts.fifo_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.edge_null) begin
                    n_state = S_POP;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state = S_USE;
                end
            end
            S_USE: begin
                o_cmd.edge_use = 1'b1;
                n_state = S_RD;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                o_out_done  = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### tb/kahn_topological_sort_tb.sv
// Self-checking testbench for kahn_topological_sort: loads random and directed
// graphs, runs the sort and checks every emitted vertex and summary against
// a local predictor. Depends on kts_pkg, kts_if and the block itself.
module kahn_topological_sort_tb import kts_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    kts_req_if req_if();
    kts_res_if res_if();

    kahn_topological_sort u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_req pending_reqs[$];
    t_res expected_order[$];
    int   n_total;
    int   n_accepted;
    int   n_errors;

    // sorter state
    logic [VW-1:0] g_target[MAX_EDGES];
    int            g_link[MAX_EDGES];
    int            g_head[MAX_VERTICES];
    int            g_tail[MAX_VERTICES];
    int            g_indeg[MAX_VERTICES];
    bit            g_present[MAX_VERTICES];
    int            g_edges;
    bit            g_dropped;

    function automatic void clear_graph();
        for (int v = 0; v < MAX_VERTICES; v++) begin
            g_head[v]    = MAX_EDGES;
            g_tail[v]    = MAX_EDGES;
            g_indeg[v]   = 0;
            g_present[v] = 0;
        end
        g_edges   = 0;
        g_dropped = 0;
    endfunction

    function automatic void sort_graph();
        int   ready_q[$];
        int   present;
        int   emitted;
        int   v;
        int   e;
        int   w;
        t_res r;
        present = 0;
        emitted = 0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            if (g_present[i]) begin
                present++;
                if (g_indeg[i] == 0) ready_q = {ready_q, i};
            end
        end
        while (ready_q.size() > 0) begin
            v = ready_q.pop_front();
            r = '0;
            r.vertex = VW'(v);
            expected_order = {expected_order, r};
            emitted++;
            e = g_head[v];
            while (e < MAX_EDGES && e < g_edges) begin
                w = g_target[e];
                if (g_indeg[w] > 0) begin
                    g_indeg[w]--;
                    if (g_indeg[w] == 0) ready_q = {ready_q, w};
                end
                e = g_link[e];
            end
        end
        r = '0;
        r.done_res       = 1'b1;
        r.unsorted_count = CW'(present - emitted);
        r.edges_dropped  = g_dropped;
        expected_order = {expected_order, r};
        clear_graph();
    endfunction

    function automatic void predict_request(t_req q);
        int s;
        int d;
        if (q.action == ACT_RUN) begin
            sort_graph();
            return;
        end
        s = q.src_vertex;
        d = q.dst_vertex;
        g_present[s] = 1;
        g_present[d] = 1;
        if (g_edges >= MAX_EDGES) begin
            g_dropped = 1;
            return;
        end
        g_target[g_edges] = VW'(d);
        g_link[g_edges]   = MAX_EDGES;
        if (g_tail[s] < MAX_EDGES) g_link[g_tail[s]] = g_edges;
        else g_head[s] = g_edges;
        g_tail[s] = g_edges;
        g_indeg[d]++;
        g_edges++;
    endfunction

    function automatic void add_req(logic act, int s, int d);
        t_req q;
        q.action     = act;
        q.src_vertex = VW'(s);
        q.dst_vertex = VW'(d);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic int send_idle_pct();
        int ph;
        ph = n_total > 0 ? n_accepted * 3 / n_total : 0;
        return ph == 0 ? 32 : (ph == 1 ? 87 : 0);
    endfunction

    function automatic int recv_idle_pct();
        int ph;
        ph = n_total > 0 ? n_accepted * 3 / n_total : 0;
        return ph == 0 ? 87 : (ph == 1 ? 32 : 0);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle_pct()) begin
                req_if.valid <= 1'b1;
                req_if.data  <= pending_reqs.pop_front();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            predict_request(req_if.data);
            n_accepted++;
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct());
            if (res_if.valid && res_if.ready) begin
                if (expected_order.size() == 0) begin
                    $error("unexpected result %p", res_if.data);
                    n_errors++;
                end else begin
                    t_res x;
                    x = expected_order.pop_front();
                    if (res_if.data.vertex !== x.vertex) begin
                        $error("vertex: expected %0d actual %0d", x.vertex, res_if.data.vertex);
                        n_errors++;
                    end
                    if (res_if.data.done_res !== x.done_res) begin
                        $error("done_res: expected %0d actual %0d",
                               x.done_res, res_if.data.done_res);
                        n_errors++;
                    end
                    if (res_if.data.unsorted_count !== x.unsorted_count) begin
                        $error("unsorted_count: expected %0d actual %0d",
                               x.unsorted_count, res_if.data.unsorted_count);
                        n_errors++;
                    end
                    if (res_if.data.edges_dropped !== x.edges_dropped) begin
                        $error("edges_dropped: expected %0d actual %0d",
                               x.edges_dropped, res_if.data.edges_dropped);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        int n_edges;
        int mask;
        int a;
        int b;
        int mode;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_accepted   = 0;
        n_errors     = 0;
        n_total      = 0;
        clear_graph();

        // directed: empty run, DAG, duplicates, self loop, cycle, extremes
        add_req(ACT_RUN, 31, 31);
        add_req(ACT_ADD, 0, 1);
        add_req(ACT_ADD, 0, 2);
        add_req(ACT_ADD, 1, 3);
        add_req(ACT_ADD, 2, 3);
        add_req(ACT_ADD, 3, 31);
        add_req(ACT_ADD, 4, 5);
        add_req(ACT_ADD, 4, 5);
        add_req(ACT_ADD, 5, 6);
        add_req(ACT_ADD, 7, 7);
        add_req(ACT_ADD, 8, 9);
        add_req(ACT_ADD, 9, 8);
        add_req(ACT_ADD, 9, 10);
        add_req(ACT_RUN, 0, 0);
        add_req(ACT_ADD, 31, 0);
        add_req(ACT_ADD, 21, 10);
        add_req(ACT_RUN, 10, 21);

        // full edge store: a few more than fit, then run
        for (int i = 0; i < MAX_EDGES + 4; i++) begin
            a = $urandom_range(30, 0);
            add_req(ACT_ADD, a, $urandom_range(31, a + 1));
        end
        add_req(ACT_RUN, $urandom_range(31, 0), $urandom_range(31, 0));

        // random graphs, mostly acyclic under a random id relabeling
        while (pending_reqs.size() < 400) begin
            n_edges = $urandom_range(24, 0);
            mode    = $urandom_range(3, 0);
            mask    = $urandom_range(31, 0);
            for (int i = 0; i < n_edges; i++) begin
                if (mode == 0) begin
                    add_req(ACT_ADD, $urandom_range(31, 0), $urandom_range(31, 0));
                end else begin
                    a = $urandom_range(30, 0);
                    b = $urandom_range(31, a + 1);
                    add_req(ACT_ADD, a ^ mask, b ^ mask);
                end
            end
            add_req(ACT_RUN, $urandom_range(31, 0), $urandom_range(31, 0));
        end
        n_total = pending_reqs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !req_if.valid && expected_order.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && expected_order.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
